@@ hw/rtl/apsp_pkg.sv @@
package apsp_pkg;

  localparam int MAX_NODES_DEF = 64;
  localparam int MAX_RESULTS   = 64;
  localparam int RES_W         = $clog2(MAX_RESULTS);
  localparam int COST_W        = 30;
  localparam int TAX_W         = 16;
  localparam int NC_W          = 7;
  localparam int VAL_W         = 17;
  localparam int PN_W          = 6;
  localparam logic [COST_W-1:0] INF_COST = 30'h3f3f3f3f;

  typedef enum logic [1:0] {
    CMD_COST  = 2'd0,
    CMD_TAX   = 2'd1,
    CMD_RUN   = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    CNT_HOLD,
    CNT_CLR,
    CNT_J,
    CNT_I,
    CNT_K
  } cnt_op_t;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_BAD,
    EM_SAME,
    EM_STEP,
    EM_LAST
  } emit_t;

  typedef struct packed {
    logic    wr_cost;
    logic    wr_tax;
    logic    q_latch;
    cnt_op_t cnt_op;
    logic    init_wr;
    logic    relax_wr;
    logic    row_sel;
    logic    q_sel;
    logic    cap_row;
    logic    q_start;
    logic    cap_cost;
    logic    q_adv;
    emit_t   emit;
  } ctl_t;

  typedef struct packed {
    logic n_zero;
    logic j_last;
    logic i_last;
    logic k_last;
    logic q_bad;
    logic q_same;
    logic cur_eq_d;
    logic cnt_max;
    logic nxt_bad;
    logic out_free;
  } sts_t;

endpackage

@@ hw/rtl/apsp_ctrl.sv @@
module apsp_ctrl import apsp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] cmd,
  output logic       in_stall,
  input  sts_t       sts,
  output ctl_t       ctl
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_ROW,
    S_ROWC,
    S_RD,
    S_UPD,
    S_QCHK,
    S_QCOST,
    S_WALK,
    S_STEP
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctl        = '0;
    ctl.cnt_op = CNT_HOLD;
    ctl.emit   = EM_NONE;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.q_latch = 1'b1;
          unique case (cmd_t'(cmd))
            CMD_COST: ctl.wr_cost = 1'b1;
            CMD_TAX:  ctl.wr_tax = 1'b1;
            CMD_RUN: begin
              if (!sts.n_zero) begin
                ctl.cnt_op = CNT_CLR;
                state_next = S_INIT;
              end
            end
            CMD_QUERY: state_next = S_QCHK;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_INIT: begin
        ctl.init_wr = 1'b1;
        if (sts.j_last) begin
          if (sts.i_last) begin
            ctl.cnt_op = CNT_CLR;
            state_next = S_ROW;
          end else begin
            ctl.cnt_op = CNT_I;
          end
        end else begin
          ctl.cnt_op = CNT_J;
        end
      end
      S_ROW: begin
        ctl.row_sel = 1'b1;
        state_next  = S_ROWC;
      end
      S_ROWC: begin
        ctl.cap_row = 1'b1;
        state_next  = S_RD;
      end
      S_RD: begin
        state_next = S_UPD;
      end
      S_UPD: begin
        ctl.relax_wr = 1'b1;
        if (sts.j_last) begin
          if (sts.i_last) begin
            if (sts.k_last) begin
              state_next = S_IDLE;
            end else begin
              ctl.cnt_op = CNT_K;
              state_next = S_ROW;
            end
          end else begin
            ctl.cnt_op = CNT_I;
            state_next = S_ROW;
          end
        end else begin
          ctl.cnt_op = CNT_J;
          state_next = S_RD;
        end
      end
      S_QCHK: begin
        ctl.q_sel = 1'b1;
        if (sts.q_bad) begin
          if (sts.out_free) begin
            ctl.emit   = EM_BAD;
            state_next = S_IDLE;
          end
        end else if (sts.q_same) begin
          if (sts.out_free) begin
            ctl.emit   = EM_SAME;
            state_next = S_IDLE;
          end
        end else begin
          ctl.q_start = 1'b1;
          state_next  = S_QCOST;
        end
      end
      S_QCOST: begin
        ctl.q_sel    = 1'b1;
        ctl.cap_cost = 1'b1;
        state_next   = S_WALK;
      end
      S_WALK: begin
        ctl.q_sel = 1'b1;
        if (sts.cur_eq_d || sts.cnt_max) begin
          if (sts.out_free) begin
            ctl.emit   = EM_LAST;
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        ctl.q_sel = 1'b1;
        if (sts.out_free) begin
          if (sts.nxt_bad) begin
            ctl.emit   = EM_LAST;
            state_next = S_IDLE;
          end else begin
            ctl.emit   = EM_STEP;
            ctl.q_adv  = 1'b1;
            state_next = S_WALK;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/apsp_dpath.sv @@
module apsp_dpath import apsp_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [NC_W-1:0]   cfg_data,
  input  logic [PN_W-1:0]   src_node,
  input  logic [PN_W-1:0]   dst_node,
  input  logic [VAL_W-1:0]  value,
  input  ctl_t              ctl,
  output sts_t              sts,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PN_W-1:0]   path_node,
  output logic [COST_W-1:0] total_cost,
  output logic              reachable,
  output logic              last
);

  localparam int NW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int AW    = 2 * NW;
  localparam int CW    = (NW + 1 > NC_W) ? NW + 1 : NC_W;
  localparam int DEPTH = 1 << AW;

  logic [COST_W-1:0] dist_mem [DEPTH];
  logic [NW-1:0]     nh_mem   [DEPTH];
  logic [TAX_W-1:0]  tax_mem  [MAX_NODES];

  logic [NC_W-1:0]   node_count;
  logic [CW-1:0]     n_lim;
  logic [NW-1:0]     ci, cj, ck;
  logic [PN_W-1:0]   qs, qd;
  logic [NW-1:0]     cur;
  logic [RES_W-1:0]  cnt;
  logic [COST_W-1:0] rd_a, rd_b;
  logic [NW-1:0]     nh_rd;
  logic [TAX_W-1:0]  tax_rd;
  logic [COST_W-1:0] dik;
  logic [NW-1:0]     nhik;
  logic [TAX_W-1:0]  taxk;
  logic [COST_W-1:0] cost;
  logic              reach;
  logic [AW-1:0]     addr_a, addr_b, addr_nh, addr_ld;
  logic [31:0]       via_sum;
  logic [COST_W-1:0] via;
  logic              better;
  logic              ld_ok;
  logic [CW-1:0]     max_c;

  assign max_c = CW'(MAX_NODES);
  assign n_lim = (CW'(node_count) > max_c) ? max_c : CW'(node_count);

  assign addr_ld = {NW'(src_node), NW'(dst_node)};
  assign ld_ok   = (CW'(src_node) < max_c) && (CW'(dst_node) < max_c);
  assign addr_a  = ctl.q_sel ? {NW'(qs), NW'(qd)} : (ctl.row_sel ? {ci, ck} : {ci, cj});
  assign addr_b  = {ck, cj};
  assign addr_nh = ctl.q_sel ? {cur, NW'(qd)} : {ci, ck};

  assign via_sum = 32'(dik) + 32'(rd_b) + 32'(taxk);
  assign via     = (via_sum > 32'(INF_COST)) ? INF_COST : COST_W'(via_sum);
  assign better  = rd_a > via;

  assign sts.n_zero   = (n_lim == '0);
  assign sts.j_last   = (CW'(cj) == n_lim - CW'(1));
  assign sts.i_last   = (CW'(ci) == n_lim - CW'(1));
  assign sts.k_last   = (CW'(ck) == n_lim - CW'(1));
  assign sts.q_bad    = (CW'(qs) >= max_c) || (CW'(qd) >= max_c);
  assign sts.q_same   = (qs == qd);
  assign sts.cur_eq_d = (cur == NW'(qd));
  assign sts.cnt_max  = (cnt == RES_W'(MAX_RESULTS - 1));
  assign sts.nxt_bad  = (CW'(nh_rd) >= max_c);
  assign sts.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NC_W'(1);
    end else if (cfg_we) begin
      node_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_cost && ld_ok) begin
      dist_mem[addr_ld] <= value[VAL_W-1] ? INF_COST : COST_W'(value[TAX_W-1:0]);
    end else if (ctl.relax_wr && better) begin
      dist_mem[{ci, cj}] <= via;
    end
    rd_a <= dist_mem[addr_a];
    rd_b <= dist_mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (ctl.init_wr) begin
      nh_mem[{ci, cj}] <= cj;
    end else if (ctl.relax_wr && better) begin
      nh_mem[{ci, cj}] <= nhik;
    end
    nh_rd <= nh_mem[addr_nh];
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_tax && (CW'(src_node) < max_c)) begin
      tax_mem[NW'(src_node)] <= value[VAL_W-1] ? '0 : value[TAX_W-1:0];
    end
    tax_rd <= tax_mem[ck];
  end

  always_ff @(posedge clk) begin
    unique case (ctl.cnt_op)
      CNT_CLR: begin
        ci <= '0;
        cj <= '0;
        ck <= '0;
      end
      CNT_J: cj <= cj + NW'(1);
      CNT_I: begin
        cj <= '0;
        ci <= ci + NW'(1);
      end
      CNT_K: begin
        cj <= '0;
        ci <= '0;
        ck <= ck + NW'(1);
      end
      default: begin
        ci <= ci;
      end
    endcase
    if (ctl.cap_row) begin
      dik  <= rd_a;
      nhik <= nh_rd;
      taxk <= tax_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.q_latch) begin
      qs <= src_node;
      qd <= dst_node;
    end
    if (ctl.q_start) begin
      cur <= NW'(qs);
      cnt <= '0;
    end else if (ctl.q_adv) begin
      cur <= nh_rd;
      cnt <= cnt + RES_W'(1);
    end
    if (ctl.cap_cost) begin
      reach <= rd_a < INF_COST;
      cost  <= (rd_a < INF_COST) ? rd_a : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit != EM_NONE) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.emit)
      EM_BAD: begin
        path_node  <= qs;
        total_cost <= '0;
        reachable  <= 1'b0;
        last       <= 1'b1;
      end
      EM_SAME: begin
        path_node  <= qs;
        total_cost <= '0;
        reachable  <= 1'b1;
        last       <= 1'b1;
      end
      EM_STEP: begin
        path_node  <= PN_W'(cur);
        total_cost <= '0;
        reachable  <= reach;
        last       <= 1'b0;
      end
      EM_LAST: begin
        path_node  <= PN_W'(cur);
        total_cost <= cost;
        reachable  <= reach;
        last       <= 1'b1;
      end
      default: begin
        path_node <= path_node;
      end
    endcase
  end

endmodule

@@ hw/rtl/all_pairs_shortest_path_node_tax.sv @@
// Shortest paths between all node pairs, with a transit tax charged at each
// intermediate node. Items arrive on the input channel (in_valid, in_stall)
// as a command with two node numbers and a value. Link cost and tax loads
// are taken one transfer per cycle while the block is idle. A run command
// with n active nodes first resets the next-hop table, then relaxes the
// distance table once per intermediate node, walking it through the
// two-read-port distance memory. A query produces one result per path node
// on the output channel (out_valid, out_stall); each next-hop lookup is a
// registered memory read. The last result carries the total cost. The input
// is stalled while a run or query is in progress, and a stalled output holds
// the query walk at its current node. The node count register is written
// through cfg_valid and cfg_ready; the user must write it only while the
// block is idle, and the block itself does not enforce this.
// Reset returns the controller to idle, empties the output register and sets
// the node count to one; the tables keep their contents and must be loaded
// before use.
module all_pairs_shortest_path_node_tax import apsp_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [NC_W-1:0]   cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        cmd,
  input  logic [PN_W-1:0]   src_node,
  input  logic [PN_W-1:0]   dst_node,
  input  logic [VAL_W-1:0]  value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PN_W-1:0]   path_node,
  output logic [COST_W-1:0] total_cost,
  output logic              reachable,
  output logic              last
);

  ctl_t ctl;
  sts_t sts;

  assign cfg_ready = 1'b1;

  apsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  apsp_dpath #(
    .MAX_NODES (MAX_NODES)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .src_node   (src_node),
    .dst_node   (dst_node),
    .value      (value),
    .ctl        (ctl),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .path_node  (path_node),
    .total_cost (total_cost),
    .reachable  (reachable),
    .last       (last)
  );

endmodule

@@ hw/rtl/apsp_checker.sv @@
module apsp_checker import apsp_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic [PN_W-1:0]   path_node,
  input logic [COST_W-1:0] total_cost,
  input logic              reachable,
  input logic              last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(path_node) && $stable(total_cost)
      && $stable(last))
    else $error("stalled result changed");

  a_cost_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> total_cost == '0)
    else $error("cost shown before the final node");

  a_unreach_cost: assert property (@(posedge clk) disable iff (rst)
    out_valid && !reachable |-> total_cost == '0)
    else $error("cost shown for an unreachable pair");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present after reset");

endmodule

bind all_pairs_shortest_path_node_tax apsp_checker u_apsp_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .path_node  (path_node),
  .total_cost (total_cost),
  .reachable  (reachable),
  .last       (last)
);

@@ tb/sv/tb_all_pairs_shortest_path_node_tax.sv @@
module tb_all_pairs_shortest_path_node_tax;
  import apsp_pkg::*;

  typedef struct {
    cmd_t        op;
    logic [5:0]  s;
    logic [5:0]  d;
    logic [16:0] v;
  } path_cmd_t;

  typedef struct {
    logic [5:0]  node;
    logic [29:0] cost;
    logic        reach;
    logic        fin;
  } hop_t;

  logic              clk;
  logic              rst;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [NC_W-1:0]   cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        cmd;
  logic [PN_W-1:0]   src_node;
  logic [PN_W-1:0]   dst_node;
  logic [VAL_W-1:0]  value;
  logic              out_valid;
  logic              out_stall;
  logic [PN_W-1:0]   path_node;
  logic [COST_W-1:0] total_cost;
  logic              reachable;
  logic              last;

  all_pairs_shortest_path_node_tax dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .src_node(src_node), .dst_node(dst_node), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .path_node(path_node), .total_cost(total_cost),
    .reachable(reachable), .last(last)
  );

  path_cmd_t   cmd_queue[$];
  path_cmd_t   cur_cmd;
  hop_t        expected_hops[$];
  logic [29:0] dist_mem [0:4095];
  logic [5:0]  hop_mem [0:4095];
  logic [15:0] tax_mem [0:63];
  logic [6:0]  node_cnt;
  int          walked_n;
  int          errors;
  int          cycles;
  int          send_gap;
  int          stall_gap;
  bit          idle_on;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic add_hop(input logic [5:0] node, input logic [29:0] cost, input logic reach,
                         input logic fin);
    hop_t h;
    h.node = node;
    h.cost = cost;
    h.reach = reach;
    h.fin = fin;
    expected_hops.insert(expected_hops.size(), h);
  endtask

  task automatic relax_all();
    int n;
    logic [63:0] via;
    n = (node_cnt > 64) ? 64 : node_cnt;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        hop_mem[i*64+j] = j[5:0];
    for (int k = 0; k < n; k++)
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) begin
          via = 64'(dist_mem[i*64+k]) + 64'(dist_mem[k*64+j]) + 64'(tax_mem[k]);
          if (via > 64'(INF_COST)) via = 64'(INF_COST);
          if (64'(dist_mem[i*64+j]) > via) begin
            dist_mem[i*64+j] = via[29:0];
            hop_mem[i*64+j] = hop_mem[i*64+k];
          end
        end
  endtask

  task automatic walk_path(input logic [5:0] s, input logic [5:0] d);
    logic [29:0] pair_cost;
    logic [29:0] cost;
    logic        reach;
    logic [5:0]  cur;
    int          k;
    if (s == d) begin
      add_hop(s, 30'd0, 1'b1, 1'b1);
      return;
    end
    pair_cost = dist_mem[s*64+d];
    reach = pair_cost < INF_COST;
    cost = reach ? pair_cost : 30'd0;
    cur = s;
    k = 0;
    while (cur != d && k != MAX_RESULTS - 1) begin
      add_hop(cur, 30'd0, reach, 1'b0);
      cur = hop_mem[cur*64+d];
      k++;
    end
    add_hop(cur, cost, reach, 1'b1);
  endtask

  task automatic apply_cmd(input path_cmd_t c);
    case (c.op)
      CMD_COST: dist_mem[c.s*64+c.d] = c.v[16] ? INF_COST : {14'd0, c.v[15:0]};
      CMD_TAX:  tax_mem[c.s] = c.v[16] ? 16'd0 : c.v[15:0];
      CMD_RUN:  relax_all();
      default:  walk_path(c.s, c.d);
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) apply_cmd(cur_cmd);
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (cmd_queue.size() > 0) begin
          cur_cmd = cmd_queue.pop_front();
          cmd <= cur_cmd.op;
          src_node <= cur_cmd.s;
          dst_node <= cur_cmd.d;
          value <= cur_cmd.v;
          in_valid <= 1'b1;
          if (idle_on && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 16);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    hop_t e;
    if (rst) begin
      out_stall <= 1'b0;
      stall_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_hops.size() == 0) begin
          if (errors < 10) $display("unexpected result: node %0d cost %0d", path_node,
                                    total_cost);
          errors++;
        end else begin
          e = expected_hops.pop_front();
          if (path_node !== e.node || total_cost !== e.cost || reachable !== e.reach ||
              last !== e.fin) begin
            if (errors < 10)
              $display({"mismatch: expected node %0d cost %0d reach %0d last %0d, ",
                        "got %0d %0d %0d %0d"},
                       e.node, e.cost, e.reach, e.fin, path_node, total_cost, reachable, last);
            errors++;
          end
        end
      end
      if (stall_gap > 0) begin
        stall_gap--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_gap = $urandom_range(0, 15);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 4000000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_cmd(input cmd_t op, input int s, input int d, input logic [16:0] v);
    path_cmd_t c;
    c.op = op;
    c.s = s[5:0];
    c.d = d[5:0];
    c.v = v;
    cmd_queue.insert(cmd_queue.size(), c);
  endtask

  function automatic logic [16:0] rand_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 17'h1ffff;
    if (r == 2) return 17'h10000 | 17'($urandom);
    if (r == 3) return 17'hffff;
    if (r == 4) return 17'($urandom_range(0, 65535));
    return 17'($urandom_range(0, 40));
  endfunction

  task automatic drain();
    while (cmd_queue.size() != 0 || in_valid || in_stall || expected_hops.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_count(input logic [6:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    node_cnt = v;
  endtask

  task automatic graph_phase(input logic [6:0] cnt, input int queries);
    int n;
    write_count(cnt);
    n = (cnt > 64) ? 64 : cnt;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        push_cmd(CMD_COST, i, j,
                 (n > 8 && $urandom_range(0, 3) != 0) ? 17'h1ffff : rand_value());
    for (int i = 0; i < n; i++) push_cmd(CMD_TAX, i, 0, rand_value());
    push_cmd(CMD_RUN, $urandom_range(0, 63), $urandom_range(0, 63), 17'($urandom));
    if (n > 0) walked_n = n;
    for (int q = 0; q < queries; q++) begin
      case ($urandom_range(0, 7))
        0: push_cmd(CMD_COST, $urandom_range(0, 63), $urandom_range(0, 63), rand_value());
        1: push_cmd(CMD_TAX, $urandom_range(0, 63), $urandom_range(0, 63), rand_value());
        2: begin
          push_cmd(CMD_QUERY, $urandom_range(0, 63) % walked_n, 0, 17'($urandom));
          cmd_queue[$].d = cmd_queue[$].s;
        end
        default: push_cmd(CMD_QUERY, $urandom_range(0, walked_n - 1),
                          $urandom_range(0, walked_n - 1), 17'($urandom));
      endcase
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    cmd = CMD_COST;
    src_node = '0;
    dst_node = '0;
    value = '0;
    out_stall = 1'b0;
    errors = 0;
    cycles = 0;
    node_cnt = 7'd1;
    walked_n = 0;
    idle_on = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    push_cmd(CMD_QUERY, 63, 63, 17'h1ffff);
    push_cmd(CMD_QUERY, 0, 0, 17'h0);
    push_cmd(CMD_COST, 0, 0, 17'hffff);
    push_cmd(CMD_COST, 63, 63, 17'h1ffff);
    push_cmd(CMD_TAX, 0, 0, 17'hffff);
    push_cmd(CMD_TAX, 63, 63, 17'h10000);
    push_cmd(CMD_RUN, 0, 0, 17'h0);
    push_cmd(CMD_QUERY, 0, 0, 17'h0);
    write_count(7'd2);
    push_cmd(CMD_COST, 0, 0, 17'd0);
    push_cmd(CMD_COST, 0, 1, 17'h1ffff);
    push_cmd(CMD_COST, 1, 0, 17'd5);
    push_cmd(CMD_COST, 1, 1, 17'd0);
    push_cmd(CMD_TAX, 0, 0, 17'd0);
    push_cmd(CMD_TAX, 1, 0, 17'hffff);
    push_cmd(CMD_RUN, 0, 0, 17'd0);
    push_cmd(CMD_QUERY, 0, 1, 17'd0);
    push_cmd(CMD_QUERY, 1, 0, 17'd0);
    push_cmd(CMD_QUERY, 1, 1, 17'd0);
    push_cmd(CMD_RUN, 0, 0, 17'd0);
    push_cmd(CMD_QUERY, 1, 0, 17'd0);

    graph_phase(7'd3, 25);
    graph_phase(7'd6, 30);
    graph_phase(7'd1, 15);
    graph_phase(7'd8, 35);
    graph_phase(7'd4, 25);
    graph_phase(7'd0, 10);
    drain();
    idle_on = 1'b0;
    graph_phase(7'd5, 40);
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
